// File: hw/rtl/rsh_pkg.sv
// ============================================================================
// rsh_pkg: shared definitions for the RGB 3x3 sharpen core
// Widths, register indexes, reset geometry and the per-channel sharpen helper.
// ============================================================================
package rsh_pkg;

    // Geometry and field widths.
    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int COUNT_CAP        = 1024;
    localparam int MIN_DIM          = 3;
    localparam int DIM_W            = 11;
    localparam int COORD_W          = 10;
    localparam int CHAN_W           = 8;
    localparam int PIX_W            = 3 * CHAN_W;
    localparam int SUM_W            = 11;
    localparam int DEF_IMAGE_WIDTH  = 800;
    localparam int DEF_IMAGE_HEIGHT = 450;

    // Stream and configuration port widths.
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 48;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 11;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 8'd0,
        REG_IMAGE_HEIGHT = 8'd1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0]   pixel_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [SUM_W-1:0]   nsum_t;

    // Limit a frame dimension to MIN_DIM..cap.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] cap);
        logic [DIM_W-1:0] res;
        if (v < DIM_W'(MIN_DIM)) begin
            res = DIM_W'(MIN_DIM);
        end else if (v > cap) begin
            res = cap;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Nine times the center minus the neighbor sum, limited to 0..255.
    function automatic logic [CHAN_W-1:0] sharpen_chan(input logic [CHAN_W-1:0] ctr,
                                                       input nsum_t nsum);
        logic [SUM_W:0]    nine;
        logic [SUM_W:0]    diff;
        logic [CHAN_W-1:0] res;
        nine = {1'b0, ctr, 3'b000} + (SUM_W+1)'(ctr);
        diff = nine - (SUM_W+1)'(nsum);
        if (nine < (SUM_W+1)'(nsum)) begin
            res = '0;
        end else if (diff > (SUM_W+1)'(255)) begin
            res = '1;
        end else begin
            res = diff[CHAN_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/rgb_sharpen_3x3_core.sv
// ============================================================================
// rgb_sharpen_3x3_core: streaming 3x3 sharpen filter for RGB pixels
// Two line-buffer memories feed a 3x3 window; interior pixels are sharpened,
// border pixels pass through, and each result carries its coordinates.
// ============================================================================
//
//  Channel   Direction  Payload
//  --------  ---------  ---------------------------------------------------
//  s_        in         tdata: red_in, green_in, blue_in
//  m_        out        tdata: colors, out_col, out_row; tlast; tuser
//  cfg_      in         cfg_index, cfg_data (image_width, image_height)
//
//  One pixel per cycle while each pixel yields at most one result and m_tready
//  holds high; a pixel in the last column past the first row, or on the last
//  row past the first column, yields two or three results and holds the input
//  until all of them have gone out, since the output emits one per cycle.
//  A result passes through the line-buffer read, window and sum stage, and output.
//  Reset is synchronous; the line buffers need no clearing pass.
//  A stall on m_tready backs up through the job and read stages to s_tready.
//
module rgb_sharpen_3x3_core #(
    parameter int MAX_WIDTH = rsh_pkg::MAX_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Fields from bit 0: red_in[7:0], green_in[15:8], blue_in[23:16].
    input  logic [rsh_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: red_out, green_out, blue_out, out_col[33:24],
    // out_row[43:34], zero pad[47:44].
    output logic [rsh_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic                            m_tlast,
    // Fields from bit 0: frame_done.
    output logic                            m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rsh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rsh_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rsh_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WCAP   = (MAX_WIDTH < COUNT_CAP) ? MAX_WIDTH : COUNT_CAP;
    localparam logic [DIM_W-1:0] WCAP_D = DIM_W'(WCAP);
    localparam logic [DIM_W-1:0] HCAP_D = DIM_W'(COUNT_CAP);
    localparam logic [DIM_W-1:0] RST_W  = clamp_dim(DIM_W'(DEF_IMAGE_WIDTH), WCAP_D);
    localparam logic [DIM_W-1:0] RST_H  = clamp_dim(DIM_W'(DEF_IMAGE_HEIGHT), HCAP_D);
    localparam logic [DIM_W-1:0] ONE_D  = DIM_W'(1);
    localparam coord_t RST_W_LAST = COORD_W'(RST_W - ONE_D);
    localparam coord_t RST_H_LAST = COORD_W'(RST_H - ONE_D);

    // Line buffers: rows r-2 and r-1.
    pixel_t older_mem [MAX_WIDTH];
    pixel_t newer_mem [MAX_WIDTH];

    // Geometry and raster counters.
    coord_t w_last_reg, w_last_next;
    coord_t h_last_reg, h_last_next;
    coord_t col_reg, col_next;
    coord_t row_reg, row_next;

    // Read stage.
    logic              s1_valid_reg, s1_valid_next;
    pixel_t            s1_pix_reg;
    coord_t            s1_c_reg;
    coord_t            s1_r_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    pixel_t            rd_old_reg;
    pixel_t            rd_new_reg;

    // Window.
    pixel_t win_reg [9];
    pixel_t win_next [9];

    // Job stage: pending results A (window center), B (row end), C (last row).
    logic [2:0] j_mask_reg, j_mask_next;
    logic       j_border_reg;
    pixel_t     j_ctr_reg;
    nsum_t      j_sum_reg [3];
    pixel_t     j_bpix_reg;
    pixel_t     j_cpix_reg;
    coord_t     j_c_reg;
    coord_t     j_r_reg;

    // Output register.
    logic   o_valid_reg, o_valid_next;
    pixel_t o_pix_reg;
    coord_t o_col_reg;
    coord_t o_row_reg;
    logic   o_last_reg;
    logic   o_done_reg;

    logic              accept;
    logic              cfg_wr;
    coord_t            cur_c;
    coord_t            cur_r;
    logic              at_last_col;
    logic              at_last_row;
    logic [ADDR_W-1:0] rd_addr;
    logic              s1_adv;
    logic              j_free;
    logic              o_load;
    logic              has_a, has_b, has_c;
    logic              border_a;
    coord_t            s1_x;
    coord_t            s1_y;
    nsum_t             sum_next [3];
    logic [2:0]        sel;
    logic [2:0]        remaining;
    pixel_t            sharp_pix;
    pixel_t            emit_pix;
    coord_t            emit_col;
    coord_t            emit_row;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = !s1_valid_reg || j_free;
    assign s1_adv    = s1_valid_reg && j_free;
    assign o_load    = (j_mask_reg != 3'b000) && (!o_valid_reg || m_tready);
    assign j_free    = (j_mask_reg == 3'b000) || (o_load && (remaining == 3'b000));

    // Current raster position, kept inside the frame in use.
    assign cur_c       = (col_reg > w_last_reg) ? w_last_reg : col_reg;
    assign cur_r       = (row_reg > h_last_reg) ? h_last_reg : row_reg;
    assign at_last_col = (cur_c == w_last_reg);
    assign at_last_row = (cur_r == h_last_reg);
    assign rd_addr     = ADDR_W'(cur_c);

    // Geometry writes and raster counters; a geometry write restarts the frame.
    always_comb begin
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_wr && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
            if (cfg_index == REG_IMAGE_WIDTH) begin
                w_last_next = COORD_W'(clamp_dim(cfg_data, WCAP_D) - ONE_D);
            end else begin
                h_last_next = COORD_W'(clamp_dim(cfg_data, HCAP_D) - ONE_D);
            end
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (at_last_col) begin
                col_next = '0;
                row_next = at_last_row ? '0 : cur_r + COORD_W'(1);
            end else begin
                col_next = cur_c + COORD_W'(1);
                row_next = cur_r;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg <= RST_W_LAST;
            h_last_reg <= RST_H_LAST;
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            w_last_reg <= w_last_next;
            h_last_reg <= h_last_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // Line buffers: read at acceptance, write back when the pixel leaves the
    // read stage. Neighboring pixels use different columns unless a geometry write restarts the frame between them.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_old_reg <= older_mem[rd_addr];
        end
        if (s1_adv) begin
            older_mem[s1_addr_reg] <= rd_new_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_new_reg <= newer_mem[rd_addr];
        end
        if (s1_adv) begin
            newer_mem[s1_addr_reg] <= s1_pix_reg;
        end
    end

    // Read stage control.
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg  <= s_tdata[PIX_W-1:0];
            s1_c_reg    <= cur_c;
            s1_r_reg    <= cur_r;
            s1_addr_reg <= rd_addr;
        end
    end

    // Shifted window and the results this pixel causes.
    always_comb begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = rd_old_reg;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = rd_new_reg;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s1_pix_reg;
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum_next[ch] = '0;
            for (int k = 0; k < 9; k++) begin
                if (k != 4) begin
                    sum_next[ch] = sum_next[ch] + SUM_W'(win_next[k][ch*CHAN_W +: CHAN_W]);
                end
            end
        end
    end

    assign s1_x     = s1_c_reg - COORD_W'(1);
    assign s1_y     = s1_r_reg - COORD_W'(1);
    assign has_a    = (s1_c_reg != '0) && (s1_r_reg != '0);
    assign has_b    = (s1_c_reg == w_last_reg) && (s1_r_reg != '0);
    assign has_c    = (s1_r_reg == h_last_reg);
    assign border_a = (s1_x == '0) || (s1_x == w_last_reg) ||
                      (s1_y == '0) || (s1_y == h_last_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
        end else if (s1_adv) begin
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    // Job stage: load on advance, retire one result per load of the output register.
    always_comb begin
        j_mask_next = j_mask_reg;
        if (s1_adv) begin
            j_mask_next = {has_c, has_b, has_a};
        end else if (o_load) begin
            j_mask_next = remaining;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_mask_reg <= '0;
        end else begin
            j_mask_reg <= j_mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            j_border_reg <= border_a;
            j_ctr_reg    <= win_next[4];
            j_bpix_reg   <= win_next[5];
            j_cpix_reg   <= s1_pix_reg;
            j_c_reg      <= s1_c_reg;
            j_r_reg      <= s1_r_reg;
            for (int ch = 0; ch < 3; ch++) begin
                j_sum_reg[ch] <= sum_next[ch];
            end
        end
    end

    // Pick the oldest pending result.
    assign sel[0]    = j_mask_reg[0];
    assign sel[1]    = j_mask_reg[1] && !j_mask_reg[0];
    assign sel[2]    = j_mask_reg[2] && !j_mask_reg[1] && !j_mask_reg[0];
    assign remaining = j_mask_reg & ~sel;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sharp_pix[ch*CHAN_W +: CHAN_W] =
                sharpen_chan(j_ctr_reg[ch*CHAN_W +: CHAN_W], j_sum_reg[ch]);
        end
    end

    always_comb begin
        priority if (sel[0]) begin
            emit_pix = j_border_reg ? j_ctr_reg : sharp_pix;
            emit_col = j_c_reg - COORD_W'(1);
            emit_row = j_r_reg - COORD_W'(1);
        end else if (sel[1]) begin
            emit_pix = j_bpix_reg;
            emit_col = w_last_reg;
            emit_row = j_r_reg - COORD_W'(1);
        end else begin
            emit_pix = j_cpix_reg;
            emit_col = j_c_reg;
            emit_row = j_r_reg;
        end
    end

    // Output register.
    always_comb begin
        o_valid_next = o_valid_reg;
        if (o_load) begin
            o_valid_next = 1'b1;
        end else if (m_tready) begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else begin
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_load) begin
            o_pix_reg  <= emit_pix;
            o_col_reg  <= emit_col;
            o_row_reg  <= emit_row;
            o_last_reg <= (remaining == 3'b000);
            o_done_reg <= (emit_col == w_last_reg) && (emit_row == h_last_reg);
        end
    end

    // Color fields go out red first; the stored pixel has red in its low byte.
    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - PIX_W - 2*COORD_W){1'b0}},
                       o_row_reg, o_col_reg, o_pix_reg};
    assign m_tlast  = o_last_reg;
    assign m_tuser  = o_done_reg;

endmodule

// File: hw/rtl/rsh_checker.sv
// ============================================================================
// rsh_checker: port-level checks for the RGB 3x3 sharpen core
// Watches the result channel and is bound to the top level.
// ============================================================================
module rsh_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rsh_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast,
    input logic                          m_tuser
);
    import rsh_pkg::*;

    localparam int COL_LO = PIX_W;
    localparam int ROW_LO = PIX_W + COORD_W;

    // The output register comes out of reset empty.
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled result changed");

    // The frame's final pixel is always the last result of its input pixel.
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end not marked as last of run");

    // The frame's final pixel lies at least two columns and rows from the origin.
    a_done_coords: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[COL_LO +: COORD_W] > COORD_W'(1)) &&
                                (m_tdata[ROW_LO +: COORD_W] > COORD_W'(1)))
        else $error("frame end at impossible coordinates");

endmodule

bind rgb_sharpen_3x3_core rsh_checker u_rsh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
